// File: sv/fm_voice_allocator_defines.svh
// ---------------------------------------------------------------------------
// FM voice allocator assertion macros
// Shared concurrent assertion forms for the allocator checkers.
// ---------------------------------------------------------------------------
`ifndef FM_VOICE_ALLOCATOR_DEFINES_SVH
`define FM_VOICE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FVA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("fva: implication failed");

// Next-cycle implication, disabled while reset is asserted
`define FVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("fva: next-cycle implication failed");

`endif

// File: sv/fva_pkg.sv
// ---------------------------------------------------------------------------
// FM voice allocator package
// Sizes, codes, voice store word and small helpers for the voice allocator.
// ---------------------------------------------------------------------------
package fva_pkg;

	localparam int VOICES            = 24;
	localparam int CHANNELS_PER_CHIP = 6;
	localparam int GEN_BITS          = 16;

	localparam int IDX_BITS     = $clog2(VOICES);
	localparam int SLOT_BITS    = 5;
	localparam int HGEN_BITS    = 16;
	localparam int ALG_BITS     = 3;
	localparam int RATE_BITS    = 4;
	localparam int OPS          = 4;
	localparam int SAMPLE_BITS  = 16;
	localparam int STAMP_BITS   = 32;
	localparam int LEN_BITS     = 20;
	localparam int CFG_IDX_BITS = 2;
	localparam int CHIP_BITS    = 2;
	localparam int CHAN_BITS    = 3;

	localparam int IN_DATA_BITS  = 56;
	localparam int OUT_DATA_BITS = 32;

	localparam logic [LEN_BITS-1:0]  MIN_RELEASE = LEN_BITS'(64);
	localparam logic [RATE_BITS-1:0] RATE_FAST   = RATE_BITS'(13);
	localparam logic [RATE_BITS-1:0] RATE_MID    = RATE_BITS'(8);
	localparam logic [RATE_BITS-1:0] RATE_SLOW   = RATE_BITS'(4);
	localparam logic [RATE_BITS-1:0] RATE_MAX    = '1;

	// Carrier operators per algorithm, bit n set when operator n+1 is a carrier
	localparam logic [OPS-1:0] CARRIER_MAP [8] = '{
		4'b1000, 4'b1000, 4'b1000, 4'b1000,
		4'b1100, 4'b1110, 4'b1110, 4'b1111
	};

	localparam int SPLIT_STEPS = ((1 << SLOT_BITS) - 1) / CHANNELS_PER_CHIP;

	typedef enum logic [1:0] {
		KIND_NOTE_ON  = 2'd0,
		KIND_NOTE_OFF = 2'd1,
		KIND_DROP     = 2'd2,
		KIND_TICK     = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FAST_LEN = 2'd0,
		REG_MID_LEN  = 2'd1,
		REG_SLOW_LEN = 2'd2,
		REG_LONG_LEN = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_BITS-1:0]   cnt;
		logic [RATE_BITS-1:0]  rate;
		logic [STAMP_BITS-1:0] stamp;
		logic [GEN_BITS-1:0]   gen;
	} voice_word_t;

	localparam voice_word_t VOICE_RESET = '{
		cnt:   '0,
		rate:  RATE_MAX,
		stamp: '0,
		gen:   GEN_BITS'(1)
	};

	typedef struct packed {
		logic [CHIP_BITS-1:0] chip;
		logic [CHAN_BITS-1:0] channel;
	} slot_split_t;

	// Split a slot into chip and channel by repeated compare and subtract
	function automatic slot_split_t slot_split(input logic [SLOT_BITS-1:0] slot);
		logic [SLOT_BITS-1:0] r;
		logic [SLOT_BITS-1:0] q;
		slot_split_t res;
		r = slot;
		q = '0;
		for (int k = 0; k < SPLIT_STEPS; k++) begin
			if (r >= SLOT_BITS'(CHANNELS_PER_CHIP)) begin
				r = r - SLOT_BITS'(CHANNELS_PER_CHIP);
				q = q + SLOT_BITS'(1);
			end
		end
		res.chip    = q[CHIP_BITS-1:0];
		res.channel = r[CHAN_BITS-1:0];
		return res;
	endfunction

	// Lowest release rate among the carriers of an algorithm
	function automatic logic [RATE_BITS-1:0] carrier_rate(
		input logic [ALG_BITS-1:0] alg,
		input logic [OPS-1:0][RATE_BITS-1:0] rel
	);
		logic [RATE_BITS-1:0] rr;
		logic [OPS-1:0] map;
		rr  = RATE_MAX;
		map = CARRIER_MAP[alg];
		for (int op = 0; op < OPS; op++) begin
			if (map[op] && (rel[op] < rr)) begin
				rr = rel[op];
			end
		end
		return rr;
	endfunction

endpackage

// File: sv/fm_voice_allocator.sv
// ---------------------------------------------------------------------------
// FM voice allocator
// Hands out 24 FM channels (4 chips by 6) to notes and tracks their release.
// Input stream s_*: one transaction per event (note on, note off, drop, tick),
// kind in s_tuser. Output stream m_*: exactly one result per event, status
// flag in m_tuser. cfg_*: release length registers, always ready.
// A note on scans all voices through the single read port of the voice
// store and one shared stamp comparator, one voice per cycle, then fetches
// the chosen voice; other kinds read one voice only. s_tready drops for the
// whole of an event, so a new event is not taken before the last one has
// reached write-back.
// A stalled receiver holds the result register; the next event is accepted
// meanwhile but waits at write-back until the result register frees.
// Reset clears all voices at once through per-entry valid bits (no clearing
// pass), loads the default release lengths and zeroes the stamp counter.
// ---------------------------------------------------------------------------
module fm_voice_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fva_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [fva_pkg::LEN_BITS-1:0]        cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// voice_slot, voice_gen, algorithm, op_release_0..3, sample_count
	input  logic [fva_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// kind
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// slot_out, gen_out, chip_index, channel_index, stolen, key_off, sounding
	output logic [fva_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	// status
	output logic [0:0]                          m_tuser
);
	import fva_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_FETCH = 5'b01000,
		ST_EXEC  = 5'b10000
	} state_t;

	state_t state_q;

	logic [LEN_BITS-1:0] fast_len_q, mid_len_q, slow_len_q, long_len_q;

	kind_t                  kind_q;
	logic [SLOT_BITS-1:0]   slot_q;
	logic                   slot_ok_q;
	logic [HGEN_BITS-1:0]   gen_q;
	logic [RATE_BITS-1:0]   rr_q;
	logic [SAMPLE_BITS-1:0] samples_q;

	logic [VOICES-1:0]     used_q, held_q, init_q;
	logic [STAMP_BITS-1:0] stamp_cnt_q;

	voice_word_t voice_mem_q [VOICES];
	voice_word_t rd_q;
	logic        rd_init_s1;
	voice_word_t rd_word;

	logic [IDX_BITS-1:0] idx_q, idx_s1;
	logic                cmp_vld_s1;

	logic [IDX_BITS-1:0]   free_q, rel_q, old_q;
	logic                  free_ok_q, rel_ok_q, old_ok_q;
	logic [STAMP_BITS-1:0] rel_stamp_q, old_stamp_q;

	logic [IDX_BITS-1:0] sel_q, rd_addr, pick;

	logic                     m_tvalid_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;
	logic                     out_status_q;

	logic accept, exec_go;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign exec_go   = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_len_q <= LEN_BITS'(5292);
			mid_len_q  <= LEN_BITS'(15435);
			slow_len_q <= LEN_BITS'(30870);
			long_len_q <= LEN_BITS'(52920);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FAST_LEN: fast_len_q <= cfg_data;
				REG_MID_LEN:  mid_len_q  <= cfg_data;
				REG_SLOW_LEN: slow_len_q <= cfg_data;
				REG_LONG_LEN: long_len_q <= cfg_data;
			endcase
		end
	end

	// Latch the event fields on acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= kind_t'(s_tuser);
			slot_q    <= s_tdata[4:0];
			slot_ok_q <= (s_tdata[4:0] < SLOT_BITS'(VOICES));
			gen_q     <= s_tdata[20:5];
			rr_q      <= carrier_rate(s_tdata[23:21], s_tdata[39:24]);
			samples_q <= s_tdata[55:40];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (kind_t'(s_tuser) == KIND_NOTE_ON) ? ST_SCAN : ST_FETCH;
					end
				end
				ST_SCAN: begin
					if (idx_q == IDX_BITS'(VOICES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_FETCH;
				ST_FETCH: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Advance the scan index and its compare-stage copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= '0;
		end else if (state_q == ST_SCAN) begin
			idx_q <= idx_q + IDX_BITS'(1);
		end
		idx_s1 <= idx_q;
	end

	// Choose the voice for a note on, or the handle's voice otherwise
	always_comb begin
		if (kind_q == KIND_NOTE_ON) begin
			priority if (free_ok_q) begin
				pick = free_q;
			end else if (rel_ok_q) begin
				pick = rel_q;
			end else if (old_ok_q) begin
				pick = old_q;
			end else begin
				pick = '0;
			end
		end else begin
			pick = slot_ok_q ? slot_q[IDX_BITS-1:0] : '0;
		end
	end

	assign rd_addr = (state_q == ST_SCAN) ? idx_q : pick;

	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			sel_q <= pick;
		end
	end

	// Voice store: one registered read port, one write port
	always_ff @(posedge clk) begin
		rd_q       <= voice_mem_q[rd_addr];
		rd_init_s1 <= init_q[rd_addr];
	end

	assign rd_word = rd_init_s1 ? rd_q : VOICE_RESET;

	// Shared stamp comparator: against the released or the held candidate
	logic                  cmp_used, cmp_held, cmp_best_ok, cmp_older;
	logic [STAMP_BITS-1:0] cmp_best_stamp;

	always_comb begin
		cmp_used       = used_q[idx_s1];
		cmp_held       = held_q[idx_s1];
		cmp_best_ok    = cmp_held ? old_ok_q : rel_ok_q;
		cmp_best_stamp = cmp_held ? old_stamp_q : rel_stamp_q;
		cmp_older      = !cmp_best_ok || (rd_word.stamp < cmp_best_stamp);
	end

	// Track the first free, oldest released and oldest held voices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_ok_q <= 1'b0;
			rel_ok_q  <= 1'b0;
			old_ok_q  <= 1'b0;
		end else if (accept) begin
			free_ok_q <= 1'b0;
			rel_ok_q  <= 1'b0;
			old_ok_q  <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (!cmp_used) begin
				if (!free_ok_q) begin
					free_ok_q <= 1'b1;
				end
			end else if (cmp_older) begin
				if (cmp_held) begin
					old_ok_q <= 1'b1;
				end else begin
					rel_ok_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (!cmp_used) begin
				if (!free_ok_q) begin
					free_q <= idx_s1;
				end
			end else if (cmp_older) begin
				if (cmp_held) begin
					old_q       <= idx_s1;
					old_stamp_q <= rd_word.stamp;
				end else begin
					rel_q       <= idx_s1;
					rel_stamp_q <= rd_word.stamp;
				end
			end
		end
	end

	// Execute the event on the fetched voice
	logic                  ex_used, ex_held, ex_owns, ex_we;
	logic [GEN_BITS-1:0]   ex_gen_inc;
	logic [STAMP_BITS-1:0] ex_stamp;
	logic [LEN_BITS-1:0]   ex_len, ex_left, ex_samples;
	voice_word_t           ex_word;
	logic                  ex_used_d, ex_held_d;
	logic                  res_status, res_stolen, res_key_off, res_sounding;
	logic [SLOT_BITS-1:0]  res_slot;
	logic [HGEN_BITS-1:0]  res_gen;
	slot_split_t           res_split;

	always_comb begin
		ex_used    = used_q[sel_q];
		ex_held    = held_q[sel_q];
		ex_owns    = slot_ok_q && ex_used && (rd_word.gen == GEN_BITS'(gen_q));
		ex_gen_inc = rd_word.gen + GEN_BITS'(1);
		ex_stamp   = stamp_cnt_q + STAMP_BITS'(1);
		ex_samples = LEN_BITS'(samples_q);

		priority if (rd_word.rate >= RATE_FAST) begin
			ex_len = fast_len_q;
		end else if (rd_word.rate >= RATE_MID) begin
			ex_len = mid_len_q;
		end else if (rd_word.rate >= RATE_SLOW) begin
			ex_len = slow_len_q;
		end else begin
			ex_len = long_len_q;
		end
		if (ex_len < MIN_RELEASE) begin
			ex_len = MIN_RELEASE;
		end
		ex_left = (rd_word.cnt > ex_samples) ? (rd_word.cnt - ex_samples) : '0;

		ex_word      = rd_word;
		ex_we        = 1'b0;
		ex_used_d    = ex_used;
		ex_held_d    = ex_held;
		res_status   = 1'b0;
		res_slot     = slot_q;
		res_gen      = gen_q;
		res_stolen   = 1'b0;
		res_key_off  = 1'b0;
		res_sounding = 1'b0;

		if (kind_q == KIND_NOTE_ON) begin
			ex_word.gen   = ex_used ? ex_gen_inc : rd_word.gen;
			ex_word.stamp = ex_stamp;
			ex_word.rate  = rr_q;
			ex_we         = 1'b1;
			ex_used_d     = 1'b1;
			ex_held_d     = 1'b1;
			res_slot      = SLOT_BITS'(sel_q);
			res_gen       = HGEN_BITS'(ex_word.gen);
			res_stolen    = ex_used;
			res_key_off   = ex_used;
			res_sounding  = 1'b1;
		end else if (!ex_owns) begin
			res_status = 1'b1;
		end else begin
			unique case (kind_q)
				KIND_NOTE_OFF: begin
					ex_word.cnt  = ex_len;
					ex_we        = 1'b1;
					ex_held_d    = 1'b0;
					res_key_off  = 1'b1;
					res_sounding = 1'b1;
				end
				KIND_DROP: begin
					ex_word.gen = ex_gen_inc;
					ex_we       = 1'b1;
					ex_used_d   = 1'b0;
					ex_held_d   = 1'b0;
					res_gen     = HGEN_BITS'(ex_gen_inc);
					res_key_off = 1'b1;
				end
				KIND_TICK: begin
					if (ex_held) begin
						res_sounding = 1'b1;
					end else begin
						ex_word.cnt  = ex_left;
						ex_we        = 1'b1;
						res_sounding = (ex_left != '0);
					end
				end
				default: begin
					res_status = 1'b0;
				end
			endcase
		end
		res_split = slot_split(res_slot);
	end

	// Write back the voice word
	always_ff @(posedge clk) begin
		if (exec_go && ex_we) begin
			voice_mem_q[sel_q] <= ex_word;
		end
	end

	// Update the per-voice flags and the stamp counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			held_q      <= '0;
			init_q      <= '0;
			stamp_cnt_q <= '0;
		end else if (exec_go) begin
			used_q[sel_q] <= ex_used_d;
			held_q[sel_q] <= ex_held_d;
			if (ex_we) begin
				init_q[sel_q] <= 1'b1;
			end
			if (kind_q == KIND_NOTE_ON) begin
				stamp_cnt_q <= ex_stamp;
			end
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			out_status_q <= res_status;
			out_data_q   <= {3'b000, res_sounding, res_key_off, res_stolen,
				res_split.channel, res_split.chip, res_gen, res_slot};
		end
	end

endmodule

// File: sv/fva_checker.sv
// ---------------------------------------------------------------------------
// FM voice allocator port checker
// Watches the top-level ports and flags results or handshakes that cannot
// come from a working allocator.
// ---------------------------------------------------------------------------
`include "fm_voice_allocator_defines.svh"

module fva_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [fva_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input logic [0:0]                         m_tuser
);
	import fva_pkg::*;

	// Hold a stalled result
	`FVA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Drop ready for the rest of an event once it is accepted
	`FVA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// A stale handle reports no steal, no key off and no sound
	`FVA_ASSERT_IMPLY(a_stale_quiet, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[28:26] == 3'b000)

	// A stolen voice is keyed off and sounds; the channel stays inside its chip
	`FVA_ASSERT_IMPLY(a_steal_keyoff, clk, arst_n, m_tvalid && m_tdata[26], m_tdata[27] && m_tdata[28] && (m_tdata[25:23] < CHAN_BITS'(CHANNELS_PER_CHIP)))

endmodule

bind fm_voice_allocator fva_checker u_fva_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// FM voice allocator testbench
// Drives note on, note off, drop and tick transactions into the allocator
// and scores every result against a cycle-free model of the voice table.
// The release length registers run through defaults, extremes and random
// settings. Both stream sides idle at random, and the receiver once holds
// off long enough to back up the input.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fva_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 300;
	localparam int MAX_REPORTS = 40;

	// Carrier operators per algorithm, bit n for operator n+1
	localparam logic [3:0] CARRIER_OPS [8] = '{
		4'b1000, 4'b1000, 4'b1000, 4'b1000,
		4'b1100, 4'b1110, 4'b1110, 4'b1111
	};

	typedef struct {
		kind_t                             kind;
		logic [SLOT_BITS-1:0]              slot;
		logic [HGEN_BITS-1:0]              gen;
		logic [ALG_BITS-1:0]               alg;
		logic [OPS-1:0][RATE_BITS-1:0]     rel;
		logic [SAMPLE_BITS-1:0]            samples;
	} voice_event_t;

	typedef struct {
		logic                  status;
		logic [SLOT_BITS-1:0]  slot;
		logic [HGEN_BITS-1:0]  gen;
		logic [CHIP_BITS-1:0]  chip;
		logic [CHAN_BITS-1:0]  chan;
		logic                  stolen;
		logic                  key_off;
		logic                  sounding;
	} voice_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
	logic [LEN_BITS-1:0]        cfg_data = '0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [IN_DATA_BITS-1:0]    s_tdata = '0;
	logic [1:0]                 s_tuser = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0]   m_tdata;
	logic [0:0]                 m_tuser;

	// Voice table model
	logic                   v_used  [VOICES];
	logic                   v_held  [VOICES];
	logic [GEN_BITS-1:0]    v_gen   [VOICES];
	logic [STAMP_BITS-1:0]  v_stamp [VOICES];
	logic [RATE_BITS-1:0]   v_rate  [VOICES];
	logic [LEN_BITS-1:0]    v_count [VOICES];
	logic [STAMP_BITS-1:0]  stamp_ctr;
	logic [LEN_BITS-1:0]    rel_len [4];

	voice_event_t   pending_events [$];
	voice_result_t  awaited_results [$];
	voice_event_t   cur_event;
	int             n_queued = 0;
	int             n_accepted = 0;
	int             n_errors = 0;
	int             send_gap = 0;
	int             recv_stall = 0;
	int             hold_left = 0;
	int             hold_req = 0;
	int             hold_done = 0;
	bit             no_idle = 1'b0;

	fm_voice_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, longint got, longint want);
		n_errors++;
		if (n_errors <= MAX_REPORTS) begin
			$display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
		end
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle) return 0;
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Apply one transaction to the voice table and work out its result
	function automatic voice_result_t apply_voice_event(voice_event_t ev);
		voice_result_t res;
		int s;
		int rel_i;
		int held_i;
		bit rel_ok;
		bit held_ok;
		bit found;
		logic [RATE_BITS-1:0] rr;
		logic [LEN_BITS-1:0] len;
		logic [LEN_BITS-1:0] c;
		res = '{default: '0};
		res.slot = ev.slot;
		res.gen = ev.gen;
		if (ev.kind == KIND_NOTE_ON) begin
			// free voice first, then oldest released, then oldest held
			found = 1'b0;
			rel_ok = 1'b0;
			held_ok = 1'b0;
			rel_i = 0;
			held_i = 0;
			s = 0;
			for (int i = 0; i < VOICES; i++) begin
				if (!found) begin
					if (!v_used[i]) begin
						s = i;
						found = 1'b1;
					end else if (!v_held[i]) begin
						if (!rel_ok || v_stamp[i] < v_stamp[rel_i]) begin
							rel_i = i;
							rel_ok = 1'b1;
						end
					end else if (!held_ok || v_stamp[i] < v_stamp[held_i]) begin
						held_i = i;
						held_ok = 1'b1;
					end
				end
			end
			if (!found) s = rel_ok ? rel_i : (held_ok ? held_i : 0);
			rr = '1;
			for (int op = 0; op < OPS; op++) begin
				if (CARRIER_OPS[ev.alg][op] && ev.rel[op] < rr) rr = ev.rel[op];
			end
			if (v_used[s]) begin
				res.stolen = 1'b1;
				v_gen[s] = v_gen[s] + 1'b1;
			end
			stamp_ctr = stamp_ctr + 1'b1;
			v_used[s] = 1'b1;
			v_held[s] = 1'b1;
			v_stamp[s] = stamp_ctr;
			v_rate[s] = rr;
			res.slot = SLOT_BITS'(s);
			res.gen = v_gen[s];
			res.key_off = res.stolen;
			res.sounding = 1'b1;
		end else if (ev.slot >= VOICES || !v_used[ev.slot] || v_gen[ev.slot] != ev.gen) begin
			res.status = 1'b1;
		end else begin
			s = ev.slot;
			case (ev.kind)
				KIND_NOTE_OFF: begin
					if (v_rate[s] >= 13) len = rel_len[REG_FAST_LEN];
					else if (v_rate[s] >= 8) len = rel_len[REG_MID_LEN];
					else if (v_rate[s] >= 4) len = rel_len[REG_SLOW_LEN];
					else len = rel_len[REG_LONG_LEN];
					v_held[s] = 1'b0;
					v_count[s] = (len < 64) ? LEN_BITS'(64) : len;
					res.key_off = 1'b1;
					res.sounding = 1'b1;
				end
				KIND_DROP: begin
					v_used[s] = 1'b0;
					v_held[s] = 1'b0;
					v_gen[s] = v_gen[s] + 1'b1;
					res.gen = v_gen[s];
					res.key_off = 1'b1;
				end
				default: begin
					if (v_held[s]) begin
						res.sounding = 1'b1;
					end else begin
						c = (v_count[s] > ev.samples) ? v_count[s] - ev.samples : '0;
						v_count[s] = c;
						res.sounding = (c != 0);
					end
				end
			endcase
		end
		res.chip = CHIP_BITS'(res.slot / CHANNELS_PER_CHIP);
		res.chan = CHAN_BITS'(res.slot % CHANNELS_PER_CHIP);
		return res;
	endfunction

	// Sender: present queued items, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(apply_voice_event(cur_event));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_events.size() > 0) begin
					cur_event = pending_events.pop_front();
					s_tdata <= {cur_event.samples, cur_event.rel[3], cur_event.rel[2],
						cur_event.rel[1], cur_event.rel[0], cur_event.alg,
						cur_event.gen, cur_event.slot};
					s_tuser <= cur_event.kind;
					s_tvalid <= 1'b1;
					send_gap = random_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: score each result, stall at random, honour long hold-offs
	always @(posedge clk or negedge arst_n) begin
		voice_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing awaited", m_tdata, 0);
				end else begin
					want = awaited_results.pop_front();
					if (m_tuser[0] !== want.status)
						report_mismatch("status", m_tuser[0], want.status);
					if (m_tdata[4:0] !== want.slot)
						report_mismatch("slot_out", m_tdata[4:0], want.slot);
					if (m_tdata[20:5] !== want.gen)
						report_mismatch("gen_out", m_tdata[20:5], want.gen);
					if (m_tdata[22:21] !== want.chip)
						report_mismatch("chip_index", m_tdata[22:21], want.chip);
					if (m_tdata[25:23] !== want.chan)
						report_mismatch("channel_index", m_tdata[25:23], want.chan);
					if (m_tdata[26] !== want.stolen)
						report_mismatch("stolen", m_tdata[26], want.stolen);
					if (m_tdata[27] !== want.key_off)
						report_mismatch("key_off", m_tdata[27], want.key_off);
					if (m_tdata[28] !== want.sounding)
						report_mismatch("sounding", m_tdata[28], want.sounding);
				end
			end
			if (hold_done != hold_req) begin
				hold_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 99) < 30) recv_stall = random_gap();
			end
		end
	end

	function automatic voice_event_t make_event(kind_t kind, int slot, int gen, int alg,
			int r0, int r1, int r2, int r3, int samples);
		voice_event_t ev;
		ev.kind = kind;
		ev.slot = SLOT_BITS'(slot);
		ev.gen = HGEN_BITS'(gen);
		ev.alg = ALG_BITS'(alg);
		ev.rel[0] = RATE_BITS'(r0);
		ev.rel[1] = RATE_BITS'(r1);
		ev.rel[2] = RATE_BITS'(r2);
		ev.rel[3] = RATE_BITS'(r3);
		ev.samples = SAMPLE_BITS'(samples);
		return ev;
	endfunction

	// Random item: mostly live handles, some stale ones, noise in unused fields
	function automatic voice_event_t random_voice_event(int note_on_pct);
		voice_event_t ev;
		int r;
		int live [$];
		int pick;
		ev.slot = SLOT_BITS'($urandom_range(0, 31));
		ev.gen = HGEN_BITS'($urandom);
		ev.alg = ALG_BITS'($urandom);
		for (int op = 0; op < OPS; op++) ev.rel[op] = RATE_BITS'($urandom);
		r = $urandom_range(0, 99);
		if (r < 25) ev.samples = SAMPLE_BITS'($urandom_range(0, 200));
		else if (r < 35) ev.samples = '0;
		else if (r < 45) ev.samples = '1;
		else ev.samples = SAMPLE_BITS'($urandom);
		r = $urandom_range(0, 99);
		if (r < note_on_pct) begin
			ev.kind = KIND_NOTE_ON;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 40) ev.kind = KIND_NOTE_OFF;
			else if (r < 55) ev.kind = KIND_DROP;
			else ev.kind = KIND_TICK;
			for (int i = 0; i < VOICES; i++) if (v_used[i]) live.push_back(i);
			r = $urandom_range(0, 99);
			if (live.size() > 0 && r < 80) begin
				pick = live[$urandom_range(0, live.size() - 1)];
				ev.slot = SLOT_BITS'(pick);
				ev.gen = v_gen[pick];
			end else if (r < 90) begin
				// near miss on the generation
				ev.slot = SLOT_BITS'($urandom_range(0, VOICES - 1));
				ev.gen = v_gen[ev.slot] + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
			end
		end
		return ev;
	endfunction

	task automatic queue_event(voice_event_t ev);
		pending_events.push_back(ev);
		n_queued++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (n_accepted != n_queued || awaited_results.size() != 0);
	endtask

	task automatic write_release_len(reg_idx_t idx, logic [LEN_BITS-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rel_len[idx] = value;
	endtask

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int batch;
		int sent;
		int note_on_pct;
		logic [LEN_BITS-1:0] lens [4];
		for (int i = 0; i < VOICES; i++) begin
			v_used[i] = 1'b0;
			v_held[i] = 1'b0;
			v_gen[i] = GEN_BITS'(1);
			v_stamp[i] = '0;
			v_rate[i] = '1;
			v_count[i] = '0;
		end
		stamp_ctr = '0;
		rel_len[REG_FAST_LEN] = 20'd5292;
		rel_len[REG_MID_LEN] = 20'd15435;
		rel_len[REG_SLOW_LEN] = 20'd30870;
		rel_len[REG_LONG_LEN] = 20'd52920;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every carrier pattern and rate band, release, drop, stale handles
		queue_event(make_event(KIND_NOTE_ON, 0, 0, 7, 15, 15, 15, 15, 0));
		queue_event(make_event(KIND_NOTE_ON, 0, 0, 0, 0, 0, 0, 9, 0));
		queue_event(make_event(KIND_NOTE_ON, 0, 0, 4, 15, 15, 5, 2, 0));
		queue_event(make_event(KIND_NOTE_ON, 0, 0, 5, 0, 6, 7, 4, 0));
		queue_event(make_event(KIND_NOTE_ON, 0, 0, 6, 1, 12, 13, 8, 0));
		queue_event(make_event(KIND_NOTE_ON, 0, 0, 1, 0, 0, 0, 12, 0));
		queue_event(make_event(KIND_NOTE_ON, 0, 0, 2, 0, 0, 0, 13, 0));
		queue_event(make_event(KIND_NOTE_ON, 0, 0, 3, 0, 0, 0, 3, 0));
		queue_event(make_event(KIND_NOTE_OFF, 0, 1, 0, 0, 0, 0, 0, 0));
		queue_event(make_event(KIND_TICK, 0, 1, 0, 0, 0, 0, 0, 65535));
		queue_event(make_event(KIND_TICK, 1, 1, 0, 0, 0, 0, 0, 500));
		queue_event(make_event(KIND_NOTE_OFF, 1, 1, 0, 0, 0, 0, 0, 0));
		queue_event(make_event(KIND_NOTE_OFF, 1, 1, 0, 0, 0, 0, 0, 0));
		queue_event(make_event(KIND_TICK, 1, 1, 0, 0, 0, 0, 0, 100));
		queue_event(make_event(KIND_DROP, 2, 1, 0, 0, 0, 0, 0, 0));
		queue_event(make_event(KIND_NOTE_OFF, 2, 1, 0, 0, 0, 0, 0, 0));
		queue_event(make_event(KIND_DROP, 2, 2, 0, 0, 0, 0, 0, 0));
		queue_event(make_event(KIND_TICK, 31, 16'hFFFF, 7, 15, 15, 15, 15, 65535));
		queue_event(make_event(KIND_TICK, 24, 1, 0, 0, 0, 0, 0, 1));
		queue_event(make_event(KIND_NOTE_ON, 31, 16'hFFFF, 7, 0, 0, 0, 0, 65535));
		queue_event(make_event(KIND_NOTE_OFF, 7, 0, 0, 0, 0, 0, 0, 0));
		queue_event(make_event(KIND_TICK, 0, 1, 0, 0, 0, 0, 0, 0));
		wait_drained();

		// Random phases, each under its own release length setting
		for (int phase = 0; phase < 6; phase++) begin
			no_idle = 1'b0;
			note_on_pct = 35;
			for (int k = 0; k < 4; k++) lens[k] = rel_len[k];
			case (phase)
				0: note_on_pct = 40;
				1: lens = '{20'd0, 20'd63, 20'd64, 20'hFFFFF};
				2: begin
					lens = '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF};
					note_on_pct = 70;
				end
				3: begin
					for (int k = 0; k < 4; k++) lens[k] = LEN_BITS'($urandom_range(64, 2000));
					note_on_pct = 30;
				end
				4: begin
					for (int k = 0; k < 4; k++) lens[k] = LEN_BITS'($urandom);
					no_idle = 1'b1;
				end
				default: begin
					for (int k = 0; k < 4; k++) lens[k] = LEN_BITS'($urandom_range(64, 600));
					note_on_pct = 25;
				end
			endcase
			if (phase != 0) begin
				for (int k = 0; k < 4; k++) write_release_len(reg_idx_t'(k), lens[k]);
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				batch = $urandom_range(1, 8);
				for (int b = 0; b < batch; b++) queue_event(random_voice_event(note_on_pct));
				sent += batch;
				// back up the block behind a stalled receiver once
				if (phase == 2 && sent == batch) hold_req++;
				while (n_accepted != n_queued) @(posedge clk);
			end
			wait_drained();
		end

		repeat (60) @(posedge clk);
		if (n_errors == 0 && awaited_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
